FILE: sv/mnp_pkg.sv
// Package for the melody notation parser: parse stages, character codes,
// result struct and the fixed letter and frequency tables. No dependencies.
`default_nettype none

package mnp_pkg;

   typedef enum logic [3:0] {
      STAGE_IDLE,
      STAGE_OCTAVE,
      STAGE_ACCID,
      STAGE_DURATION,
      STAGE_DOT,
      STAGE_KEY_DIR,
      STAGE_KEY_NOTE
   } stage_type;

   localparam logic [7:0] CHAR_END    = 8'h00;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;  // +
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;  // -
   localparam logic [7:0] CHAR_SHARP  = 8'h23;  // #
   localparam logic [7:0] CHAR_FLAT   = 8'h40;  // @
   localparam logic [7:0] CHAR_NATURAL = 8'h24; // $
   localparam logic [7:0] CHAR_DOT    = 8'h2E;  // .
   localparam logic [7:0] CHAR_OPEN   = 8'h5B;  // [
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_REST   = 8'h50;  // P
   localparam logic [7:0] CHAR_DIG1   = 8'h31;
   localparam logic [7:0] CHAR_DIG2   = 8'h32;
   localparam logic [7:0] CHAR_DIG4   = 8'h34;
   localparam logic [7:0] CHAR_DIG6   = 8'h36;
   localparam logic [7:0] CHAR_DIG8   = 8'h38;

   localparam logic signed [6:0] OCTAVE_STEP = 7'sd12;
   localparam logic signed [6:0] INDEX_MAX   = 7'sd35;
   localparam int unsigned       KEY_COUNT   = 7;

   typedef struct packed {
      logic        note_valid;
      logic        is_rest;
      logic [5:0]  note_index;
      logic [9:0]  frequency_hz;
      logic [12:0] duration_ticks;
      logic        out_of_range;
      logic        song_end;
   } result_type;

   // Semitone index of each letter A..G in the middle octave.
   function automatic logic signed [6:0] letter_base(input logic [2:0] letter);
      logic signed [6:0] base;
      case (letter)
         3'd0:    base = 7'sd21;
         3'd1:    base = 7'sd23;
         3'd2:    base = 7'sd12;
         3'd3:    base = 7'sd14;
         3'd4:    base = 7'sd16;
         3'd5:    base = 7'sd17;
         3'd6:    base = 7'sd19;
         default: base = 7'sd0;
      endcase
      return base;
   endfunction

   function automatic logic [9:0] note_freq(input logic [5:0] idx);
      logic [9:0] f;
      case (idx)
         6'd0:  f = 10'd131;  6'd1:  f = 10'd138;  6'd2:  f = 10'd147;
         6'd3:  f = 10'd155;  6'd4:  f = 10'd165;  6'd5:  f = 10'd174;
         6'd6:  f = 10'd185;  6'd7:  f = 10'd196;  6'd8:  f = 10'd207;
         6'd9:  f = 10'd220;  6'd10: f = 10'd233;  6'd11: f = 10'd247;
         6'd12: f = 10'd262;  6'd13: f = 10'd277;  6'd14: f = 10'd294;
         6'd15: f = 10'd311;  6'd16: f = 10'd330;  6'd17: f = 10'd349;
         6'd18: f = 10'd370;  6'd19: f = 10'd392;  6'd20: f = 10'd415;
         6'd21: f = 10'd440;  6'd22: f = 10'd466;  6'd23: f = 10'd494;
         6'd24: f = 10'd524;  6'd25: f = 10'd554;  6'd26: f = 10'd588;
         6'd27: f = 10'd622;  6'd28: f = 10'd660;  6'd29: f = 10'd698;
         6'd30: f = 10'd740;  6'd31: f = 10'd784;  6'd32: f = 10'd830;
         6'd33: f = 10'd880;  6'd34: f = 10'd932;  6'd35: f = 10'd988;
         default: f = 10'd0;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

FILE: sv/mnp_if.sv
// Valid/ready channel interfaces of the melody notation parser.
// Depends on nothing; the result channel mirrors mnp_pkg::result_type fields.
`default_nettype none

interface mnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface mnp_rsp_if;
   logic        valid;
   logic        ready;
   logic        note_valid;
   logic        is_rest;
   logic [5:0]  note_index;
   logic [9:0]  frequency_hz;
   logic [12:0] duration_ticks;
   logic        out_of_range;
   logic        song_end;

   modport source (output valid, output note_valid, output is_rest, output note_index,
                   output frequency_hz, output duration_ticks, output out_of_range,
                   output song_end, input ready);
   modport sink   (input valid, input note_valid, input is_rest, input note_index,
                   input frequency_hz, input duration_ticks, input out_of_range,
                   input song_end, output ready);
endinterface

`default_nettype wire

FILE: sv/melody_notation_parser.sv
// Top level of the melody notation parser: character in, note events out.
// Depends on mnp_pkg and the channel interfaces in mnp_if.sv.
`default_nettype none

// Melody notation parser. One ASCII character is taken per beat on req_chan,
// every cycle if the result side keeps up. Each character walks the parse
// cascade (octave mark, accidental, duration digit, dot, then a fresh note
// letter or key group) in combinational logic, so the
// parser state is always up to date for the next beat. A character that ends
// a note, or the end byte (0), yields one beat on rsp_chan, registered in the
// output buffer; all other characters yield nothing. Results go through a
// two-entry output buffer (output register plus skid register): req ready
// depends only on the skid register, never combinationally on rsp ready, so
// a stalled consumer costs one beat of slack before input is held off.
// Sustained rate: 1 character per cycle while the result side keeps up.
// csr_we/csr_wdata load base_unit (ticks per shortest unit) and also reset
// the remembered duration; write it only while the parser is idle.
// Durations: digits 1,2,4,8,6 give 32,16,8,4,2 x base_unit (12-bit, never wraps),
// a dot gives x3/2 rounded down. Note index is clamped to 0..35 with
// out_of_range flagged; rests report index and frequency 0.
module melody_notation_parser (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_we,
   input  wire logic [6:0] csr_wdata,
   mnp_req_if.sink    req_chan,
   mnp_rsp_if.source  rsp_chan
);

   // parser state
   mnp_pkg::stage_type stage_ff, stage_in;
   logic signed [6:0]  index_ff, index_in;
   logic [2:0]         letter_ff, letter_in;
   logic               rest_ff, rest_in;
   logic [12:0]        duration_ff, duration_in;
   logic [11:0]        last_dur_ff, last_dur_in;
   logic signed [1:0]  key_ff [mnp_pkg::KEY_COUNT];
   logic signed [1:0]  key_in [mnp_pkg::KEY_COUNT];
   logic signed [1:0]  key_dir_ff, key_dir_in;
   logic [6:0]         base_unit_ff;

   // output buffer
   logic               out_valid_ff, out_valid_in;
   mnp_pkg::result_type out_ff, out_in;
   logic               skid_valid_ff, skid_valid_in;
   mnp_pkg::result_type skid_ff, skid_in;

   logic               accept;
   logic               pop;
   logic               has_result;
   mnp_pkg::result_type result;
   logic [7:0]         c;

   assign c      = req_chan.char_code;
   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = out_valid_ff && rsp_chan.ready;

   // Parse cascade: each stage either consumes the character or passes it
   // on; the ifs are ordered so a fall-through always moves downward.
   always_comb begin
      logic              used;
      logic              emit;
      logic signed [6:0] k;
      logic [11:0]       scaled;
      logic              digit;
      logic [14:0]       dur3;
      logic signed [6:0] idx;
      logic              oor;
      logic [2:0]        key_sel;

      stage_in    = stage_ff;
      index_in    = index_ff;
      letter_in   = letter_ff;
      rest_in     = rest_ff;
      duration_in = duration_ff;
      last_dur_in = last_dur_ff;
      key_in      = key_ff;
      key_dir_in  = key_dir_ff;
      used        = 1'b0;
      emit        = 1'b0;
      k           = 7'sd0;
      scaled      = 12'd0;
      digit       = 1'b0;
      dur3        = 15'd0;
      idx         = 7'sd0;
      oor         = 1'b0;
      key_sel     = 3'd0;
      result      = '0;

      if (stage_in == mnp_pkg::STAGE_OCTAVE) begin
         if (c == mnp_pkg::CHAR_PLUS) begin
            index_in = index_in + mnp_pkg::OCTAVE_STEP;
            used     = 1'b1;
         end else if (c == mnp_pkg::CHAR_MINUS) begin
            index_in = index_in - mnp_pkg::OCTAVE_STEP;
            used     = 1'b1;
         end
         stage_in = mnp_pkg::STAGE_ACCID;
      end

      if (!used && stage_in == mnp_pkg::STAGE_ACCID) begin
         if (!rest_in) begin
            k        = 7'(key_ff[letter_in]);
            index_in = index_in + k;
            if (c == mnp_pkg::CHAR_SHARP) begin
               used = 1'b1;
               if (k != 7'sd1) index_in = index_in + 7'sd1;
            end else if (c == mnp_pkg::CHAR_FLAT) begin
               used = 1'b1;
               if (k != -7'sd1) index_in = index_in - 7'sd1;
            end else if (c == mnp_pkg::CHAR_NATURAL) begin
               used     = 1'b1;
               index_in = index_in - k;
            end
         end
         stage_in = mnp_pkg::STAGE_DURATION;
      end

      if (!used && stage_in == mnp_pkg::STAGE_DURATION) begin
         digit = 1'b1;
         case (c)
            mnp_pkg::CHAR_DIG1: scaled = {base_unit_ff, 5'd0};
            mnp_pkg::CHAR_DIG2: scaled = {1'b0, base_unit_ff, 4'd0};
            mnp_pkg::CHAR_DIG4: scaled = {2'b0, base_unit_ff, 3'd0};
            mnp_pkg::CHAR_DIG8: scaled = {3'b0, base_unit_ff, 2'd0};
            mnp_pkg::CHAR_DIG6: scaled = {4'b0, base_unit_ff, 1'b0};
            default:            digit  = 1'b0;
         endcase
         if (digit) begin
            used        = 1'b1;
            duration_in = {1'b0, scaled};
         end
         last_dur_in = duration_in[11:0];
         stage_in    = mnp_pkg::STAGE_DOT;
      end

      if (!used && stage_in == mnp_pkg::STAGE_DOT) begin
         if (c == mnp_pkg::CHAR_DOT) begin
            used        = 1'b1;
            dur3        = {2'b0, duration_in} + {1'b0, duration_in, 1'b0};
            duration_in = dur3[13:1];
         end
         emit                  = 1'b1;
         result.note_valid     = 1'b1;
         result.is_rest        = rest_in;
         result.duration_ticks = duration_in;
         if (!rest_in) begin
            idx = index_in;
            if (idx < 7'sd0) begin
               idx = 7'sd0;
               oor = 1'b1;
            end
            if (idx > mnp_pkg::INDEX_MAX) begin
               idx = mnp_pkg::INDEX_MAX;
               oor = 1'b1;
            end
            result.note_index   = idx[5:0];
            result.frequency_hz = mnp_pkg::note_freq(idx[5:0]);
            result.out_of_range = oor;
         end
         stage_in = mnp_pkg::STAGE_IDLE;
      end

      if (!used && stage_in == mnp_pkg::STAGE_IDLE) begin
         used = 1'b1;
         if (c >= mnp_pkg::CHAR_A && c <= mnp_pkg::CHAR_G) begin
            letter_in   = 3'(c - mnp_pkg::CHAR_A);
            index_in    = mnp_pkg::letter_base(letter_in);
            rest_in     = 1'b0;
            duration_in = {1'b0, last_dur_in};
            stage_in    = mnp_pkg::STAGE_OCTAVE;
         end else if (c == mnp_pkg::CHAR_REST) begin
            index_in    = -7'sd1;
            rest_in     = 1'b1;
            duration_in = {1'b0, last_dur_in};
            stage_in    = mnp_pkg::STAGE_DURATION;
         end else if (c == mnp_pkg::CHAR_OPEN) begin
            for (int i = 0; i < mnp_pkg::KEY_COUNT; i++) key_in[i] = 2'sd0;
            stage_in = mnp_pkg::STAGE_KEY_DIR;
         end
      end

      if (!used && stage_in == mnp_pkg::STAGE_KEY_DIR) begin
         used = 1'b1;
         if (c == mnp_pkg::CHAR_SHARP) begin
            key_dir_in = 2'sd1;
            stage_in   = mnp_pkg::STAGE_KEY_NOTE;
         end else if (c == mnp_pkg::CHAR_FLAT) begin
            key_dir_in = -2'sd1;
            stage_in   = mnp_pkg::STAGE_KEY_NOTE;
         end else begin
            // group closer: consumed whatever it is
            stage_in = mnp_pkg::STAGE_IDLE;
         end
      end

      if (!used && stage_in == mnp_pkg::STAGE_KEY_NOTE) begin
         if (c >= mnp_pkg::CHAR_A && c <= mnp_pkg::CHAR_G) begin
            key_sel         = 3'(c - mnp_pkg::CHAR_A);
            key_in[key_sel] = key_dir_in;
         end else begin
            stage_in = mnp_pkg::STAGE_IDLE;
         end
      end

      // end byte: flush done above, always report
      if (c == mnp_pkg::CHAR_END) begin
         stage_in = mnp_pkg::STAGE_IDLE;
         if (!emit) result = '0;
         result.song_end = 1'b1;
      end
      has_result = emit || (c == mnp_pkg::CHAR_END);
   end

   // output register + skid register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept && has_result;
            out_in       = result;
         end
      end else if (accept && has_result) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff      <= mnp_pkg::STAGE_IDLE;
         index_ff      <= 7'sd0;
         letter_ff     <= 3'd0;
         rest_ff       <= 1'b0;
         duration_ff   <= 13'd0;
         last_dur_ff   <= 12'd8;
         key_dir_ff    <= 2'sd0;
         base_unit_ff  <= 7'd8;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int i = 0; i < mnp_pkg::KEY_COUNT; i++) key_ff[i] <= 2'sd0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (csr_we) begin
            base_unit_ff <= csr_wdata;
            last_dur_ff  <= {5'd0, csr_wdata};
         end else if (accept) begin
            stage_ff    <= stage_in;
            index_ff    <= index_in;
            letter_ff   <= letter_in;
            rest_ff     <= rest_in;
            duration_ff <= duration_in;
            last_dur_ff <= last_dur_in;
            key_dir_ff  <= key_dir_in;
            key_ff      <= key_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_chan.ready          = !skid_valid_ff;
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.note_valid     = out_ff.note_valid;
   assign rsp_chan.is_rest        = out_ff.is_rest;
   assign rsp_chan.note_index     = out_ff.note_index;
   assign rsp_chan.frequency_hz   = out_ff.frequency_hz;
   assign rsp_chan.duration_ticks = out_ff.duration_ticks;
   assign rsp_chan.out_of_range   = out_ff.out_of_range;
   assign rsp_chan.song_end       = out_ff.song_end;

   // skid entry only fills behind a held output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // end byte always returns the parser to idle
   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && c == mnp_pkg::CHAR_END && !csr_we) |=> stage_ff == mnp_pkg::STAGE_IDLE)
      else $error("parser not idle after end byte");

   // clamp flag only on real notes
   a_oor_note_only: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.out_of_range) |-> (out_ff.note_valid && !out_ff.is_rest))
      else $error("out_of_range set on a rest or empty result");

   // rests carry no tone
   a_rest_silent: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.is_rest) |-> (out_ff.frequency_hz == 10'd0))
      else $error("rest result with nonzero frequency");

endmodule

`default_nettype wire
